// ----- src/ogcpm_pkg.sv -----
// ----------------------------------------------------------------------------
// ogcpm_pkg: shared definitions for the output gain, clipper and peak meter
// Widths, register indexes, reset values, mode bits and the command and
// status bundles exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package ogcpm_pkg;

  localparam int NumChannels = 4;

  localparam int ChanW    = 2;
  localparam int SampleW  = 24;
  localparam int GainW    = 16;
  localparam int ModeW    = 3;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int GainProdW = 2 * GainW;
  localparam int ProdW    = SampleW + GainProdW + 1;
  localparam int ScaledW  = ProdW - SampleW;
  localparam int ClipShift = 11;
  localparam int NumGainRegs = 4;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegMasterGain   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegModeSwitches = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMeterPeriod  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGainCh0      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGainCh1      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegGainCh2      = 3'd5;
  localparam logic [CfgIdxW-1:0] RegGainCh3      = 3'd6;

  // Bit positions inside mode_switches
  localparam int ModeMuteBit  = 0;
  localparam int ModeClipBit  = 1;
  localparam int ModeMeterBit = 2;

  // Reset values
  localparam logic [GainW-1:0] MasterGainRst   = 16'd0;
  localparam logic [ModeW-1:0] ModeSwitchesRst = 3'd2;
  localparam logic [GainW-1:0] MeterPeriodRst  = 16'd4800;
  localparam logic [GainW-1:0] ChanGainRst     = 16'd4096;

  localparam logic signed [SampleW-1:0] SampleMax = 24'sh7FFFFF;
  localparam logic signed [SampleW-1:0] SampleMin = 24'sh800000;

  localparam logic [0:0] KindSample = 1'b0;
  localparam logic [0:0] KindReport = 1'b1;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StMul    = 5'b00010,
    StScale  = 5'b00100,
    StSend   = 5'b01000,
    StReport = 5'b10000
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic scale;
    logic rep_sel;
    logic rep_adv;
    logic rep_clear;
  } cmd_t;

  typedef struct packed {
    logic chan_ok;
    logic report;
    logic rep_last;
  } status_t;

endpackage

// ----- src/ogcpm_if.sv -----
// ----------------------------------------------------------------------------
// ogcpm_in_if / ogcpm_out_if: sample and result channels
// Valid/ready channels carrying one input sample or one result item.
// ----------------------------------------------------------------------------
interface ogcpm_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [ogcpm_pkg::ChanW-1:0]           chan_index;
  logic signed [ogcpm_pkg::SampleW-1:0]  sample_in;

  modport source (output valid, output chan_index, output sample_in, input ready);
  modport sink   (input valid, input chan_index, input sample_in, output ready);
endinterface

interface ogcpm_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  kind;
  logic [ogcpm_pkg::ChanW-1:0]           out_channel;
  logic signed [ogcpm_pkg::SampleW-1:0]  out_value;
  logic                                  last;

  modport source (output valid, output kind, output out_channel, output out_value,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_channel, input out_value,
                  input last, output ready);
endinterface

// ----- src/ogcpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// ogcpm_ctrl: sequencing state machine
// Steps one sample through multiply, scale and send, then the meter report when one falls due.
// ----------------------------------------------------------------------------
module ogcpm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ogcpm_pkg::status_t  status_i,
  output ogcpm_pkg::cmd_t     cmd_o
);

  ogcpm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ogcpm_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ogcpm_pkg::StIdle: begin
        if (in_valid_i && status_i.chan_ok) begin
          state_d = ogcpm_pkg::StMul;
        end
      end
      ogcpm_pkg::StMul:   state_d = ogcpm_pkg::StScale;
      ogcpm_pkg::StScale: state_d = ogcpm_pkg::StSend;
      ogcpm_pkg::StSend: begin
        if (out_ready_i) begin
          state_d = status_i.report ? ogcpm_pkg::StReport : ogcpm_pkg::StIdle;
        end
      end
      ogcpm_pkg::StReport: begin
        if (out_ready_i && status_i.rep_last) begin
          state_d = ogcpm_pkg::StIdle;
        end
      end
      default: state_d = ogcpm_pkg::StIdle;
    endcase
  end

  assign in_ready_o  = (state_q == ogcpm_pkg::StIdle);
  assign out_valid_o = (state_q == ogcpm_pkg::StSend) || (state_q == ogcpm_pkg::StReport);

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = in_ready_o && in_valid_i && status_i.chan_ok;
    cmd_o.mul       = (state_q == ogcpm_pkg::StMul);
    cmd_o.scale     = (state_q == ogcpm_pkg::StScale);
    cmd_o.rep_sel   = (state_q == ogcpm_pkg::StReport);
    cmd_o.rep_adv   = cmd_o.rep_sel && out_ready_i;
    cmd_o.rep_clear = cmd_o.rep_adv && status_i.rep_last;
  end

endmodule

// ----- src/ogcpm_dpath.sv -----
// ----------------------------------------------------------------------------
// ogcpm_dpath: gain, clip and meter datapath
// Configuration registers, the two-step multiply, clip and saturation,
// per-channel peaks, the frame counter and the result mux.
// ----------------------------------------------------------------------------
module ogcpm_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ogcpm_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [ogcpm_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic [ogcpm_pkg::ChanW-1:0]          in_chan_i,
  input  logic signed [ogcpm_pkg::SampleW-1:0] in_sample_i,
  input  ogcpm_pkg::cmd_t                      cmd_i,
  output ogcpm_pkg::status_t                   status_o,
  output logic                                 out_kind_o,
  output logic [ogcpm_pkg::ChanW-1:0]          out_channel_o,
  output logic signed [ogcpm_pkg::SampleW-1:0] out_value_o,
  output logic                                 out_last_o
);

  localparam logic [ogcpm_pkg::ChanW-1:0] LastChan =
    ogcpm_pkg::ChanW'(ogcpm_pkg::NumChannels - 1);

  // Configuration
  logic [ogcpm_pkg::GainW-1:0] master_gain_q;
  logic [ogcpm_pkg::ModeW-1:0] mode_q;
  logic [ogcpm_pkg::GainW-1:0] period_q;
  logic [ogcpm_pkg::GainW-1:0] gain_q [ogcpm_pkg::NumGainRegs];

  // Work registers
  logic [ogcpm_pkg::ChanW-1:0]          chan_q;
  logic signed [ogcpm_pkg::SampleW-1:0] sample_q;
  logic [ogcpm_pkg::GainProdW-1:0]      gprod_q;
  logic signed [ogcpm_pkg::ProdW-1:0]   prod_q;
  logic signed [ogcpm_pkg::SampleW-1:0] res_q;

  // Meter state
  logic signed [ogcpm_pkg::SampleW-1:0] peak_q [ogcpm_pkg::NumChannels];
  logic [ogcpm_pkg::GainW-1:0]          frame_q;
  logic                                 report_q;
  logic [ogcpm_pkg::ChanW-1:0]          rep_idx_q;

  logic [ogcpm_pkg::GainW-1:0]          eff_gain;
  logic signed [ogcpm_pkg::ScaledW-1:0] scaled;
  logic signed [ogcpm_pkg::ScaledW-1:0] clip_lvl;
  logic signed [ogcpm_pkg::ScaledW-1:0] clipped;
  logic signed [ogcpm_pkg::SampleW-1:0] sat;
  logic [ogcpm_pkg::ChanW-1:0]          rd_addr;
  logic signed [ogcpm_pkg::SampleW-1:0] rd_data;
  logic [ogcpm_pkg::GainW-1:0]          frame_inc;
  logic                                 rep_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_gain_q <= ogcpm_pkg::MasterGainRst;
      mode_q        <= ogcpm_pkg::ModeSwitchesRst;
      period_q      <= ogcpm_pkg::MeterPeriodRst;
      for (int i = 0; i < ogcpm_pkg::NumGainRegs; i++) begin
        gain_q[i] <= ogcpm_pkg::ChanGainRst;
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ogcpm_pkg::RegMasterGain:   master_gain_q <= cfg_data_i;
        ogcpm_pkg::RegModeSwitches: mode_q        <= cfg_data_i[ogcpm_pkg::ModeW-1:0];
        ogcpm_pkg::RegMeterPeriod:  period_q      <= cfg_data_i;
        ogcpm_pkg::RegGainCh0:      gain_q[0]     <= cfg_data_i;
        ogcpm_pkg::RegGainCh1:      gain_q[1]     <= cfg_data_i;
        ogcpm_pkg::RegGainCh2:      gain_q[2]     <= cfg_data_i;
        ogcpm_pkg::RegGainCh3:      gain_q[3]     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign eff_gain = mode_q[ogcpm_pkg::ModeMuteBit] ? '0 : master_gain_q;

  // Floor shift by 24 is an arithmetic right shift: keep the top bits.
  assign scaled   = prod_q[ogcpm_pkg::ProdW-1:ogcpm_pkg::SampleW];
  assign clip_lvl = $signed({{(ogcpm_pkg::ScaledW - ogcpm_pkg::GainW - ogcpm_pkg::ClipShift)
                               {1'b0}}, eff_gain, {ogcpm_pkg::ClipShift{1'b0}}});

  always_comb begin
    clipped = scaled;
    if (mode_q[ogcpm_pkg::ModeClipBit] && (scaled > clip_lvl)) begin
      clipped = clip_lvl;
    end
    if (clipped > ogcpm_pkg::ScaledW'(ogcpm_pkg::SampleMax)) begin
      sat = ogcpm_pkg::SampleMax;
    end else if (clipped < ogcpm_pkg::ScaledW'(ogcpm_pkg::SampleMin)) begin
      sat = ogcpm_pkg::SampleMin;
    end else begin
      sat = clipped[ogcpm_pkg::SampleW-1:0];
    end
  end

  // One read port on the peaks: own channel while scaling, report index after.
  assign rd_addr   = cmd_i.rep_sel ? rep_idx_q : chan_q;
  assign rd_data   = peak_q[rd_addr];
  assign frame_inc = frame_q + 1'b1;
  assign rep_last  = (rep_idx_q == LastChan);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      chan_q   <= in_chan_i;
      sample_q <= in_sample_i;
      gprod_q  <= eff_gain * gain_q[in_chan_i];
    end
    if (cmd_i.mul) begin
      prod_q <= sample_q * $signed({1'b0, gprod_q});
    end
    if (cmd_i.scale) begin
      res_q <= sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ogcpm_pkg::NumChannels; i++) begin
        peak_q[i] <= '0;
      end
      frame_q   <= '0;
      report_q  <= 1'b0;
      rep_idx_q <= '0;
    end else begin
      if (cmd_i.scale) begin
        report_q <= mode_q[ogcpm_pkg::ModeMeterBit] && (chan_q == LastChan) &&
                    (frame_inc >= period_q);
        if (mode_q[ogcpm_pkg::ModeMeterBit]) begin
          if (rd_data < sat) begin
            peak_q[chan_q] <= sat;
          end
          if (chan_q == LastChan) begin
            frame_q <= frame_inc;
          end
        end
      end
      if (cmd_i.rep_clear) begin
        for (int i = 0; i < ogcpm_pkg::NumChannels; i++) begin
          peak_q[i] <= '0;
        end
        frame_q   <= '0;
        rep_idx_q <= '0;
      end else if (cmd_i.rep_adv) begin
        rep_idx_q <= rep_idx_q + 1'b1;
      end
    end
  end

  assign status_o.chan_ok  = (int'(in_chan_i) < ogcpm_pkg::NumChannels);
  assign status_o.report   = report_q;
  assign status_o.rep_last = rep_last;

  assign out_kind_o    = cmd_i.rep_sel ? ogcpm_pkg::KindReport : ogcpm_pkg::KindSample;
  assign out_channel_o = cmd_i.rep_sel ? rep_idx_q : chan_q;
  assign out_value_o   = cmd_i.rep_sel ? rd_data : res_q;
  assign out_last_o    = cmd_i.rep_sel ? rep_last : !report_q;

endmodule

// ----- src/output_gain_clip_peak_meter.sv -----
// ----------------------------------------------------------------------------
// output_gain_clip_peak_meter: output gain stage with clipper and peak meter
// Scales each Q1.23 sample by (master gain x channel gain), both Q4.12, with
// the master gain forced to zero under mute; the optional clipper limits the
// result to the master gain read as a Q1.23 level, and the value saturates to
// 24 bits. With metering on, a signed running peak is kept per channel and a
// frame is counted on each sample of the highest channel; every meter_period
// frames the peaks of all channels follow the sample in channel order and are
// cleared. One sample is in flight at a time: from accept to the next accept
// it steps through accept with the gain product, sample multiply, clip and
// saturate, and send, then one report item per peak when a report falls due;
// the two chained multiplies and the single peak read port set these steps.
// Output stalls hold the item being sent.
// ----------------------------------------------------------------------------
module output_gain_clip_peak_meter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [ogcpm_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ogcpm_pkg::CfgDataW-1:0]    cfg_data_i,
  // Sample channel
  ogcpm_in_if.sink                          in_i,
  // Result channel
  ogcpm_out_if.source                       out_o
);

  ogcpm_pkg::cmd_t    cmd;
  ogcpm_pkg::status_t status;

  // Controller: owns the handshakes and steps the datapath.
  ogcpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: config registers, multiplies, clip, peaks and result mux.
  // Payload outputs come straight from registers, so they hold while stalled.
  ogcpm_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_chan_i     (in_i.chan_index),
    .in_sample_i   (in_i.sample_in),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_kind_o    (out_o.kind),
    .out_channel_o (out_o.out_channel),
    .out_value_o   (out_o.out_value),
    .out_last_o    (out_o.last)
  );

  // Never take a new sample while a result is pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("sample accepted while a result is pending");

  // A sample on a valid channel shows its scaled item after the multiply and scale states.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (int'(in_i.chan_index) < ogcpm_pkg::NumChannels))
      |-> ##3 (out_o.valid && !out_o.kind))
    else $error("scaled item missing after accept");

  // Report items advance one channel per handshake.
  a_report_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.kind && !out_o.last)
      |=> (out_o.valid && out_o.kind &&
           out_o.out_channel == ogcpm_pkg::ChanW'($past(out_o.out_channel) + 1'b1)))
    else $error("report channel out of order");

  // The final item of a sample returns the block to taking input.
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last) |=> in_i.ready)
    else $error("not ready after final item");

endmodule
